// ----- design/gost_block_cipher_ecb_assert.svh -----
// Assertion macros shared by the cipher RTL.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef GOST_BLOCK_CIPHER_ECB_ASSERT_SVH
`define GOST_BLOCK_CIPHER_ECB_ASSERT_SVH

`ifndef SYNTHESIS

// When the condition holds, the property must hold in the same cycle.
`define GBC_ASSERT_SAME(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("gbc: same-cycle check failed");

// When the condition holds, the property must hold in the next cycle.
`define GBC_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("gbc: next-cycle check failed");

`else

`define GBC_ASSERT_SAME(lbl, cond, prop)
`define GBC_ASSERT_NEXT(lbl, cond, prop)

`endif

`endif

// ----- design/gbc_pkg.sv -----
package gbc_pkg;

	// Number of cipher rounds, one pipeline stage each.
	localparam int unsigned ROUNDS = 32;

	// Item kinds.
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_ENC  = 2'd1;
	localparam logic [1:0] KIND_DEC  = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	// Eight S-boxes, each sixteen 4-bit entries.
	typedef logic [7:0][63:0] sbox_set_t;
	// Eight 32-bit key words.
	typedef logic [7:0][31:0] key_set_t;

	// Key word used in a given round. Encryption runs 0..7 three times, then 7..0;
	// decryption runs 0..7 once, then 7..0 three times.
	function automatic logic [2:0] key_index(input logic [4:0] rnd, input logic dec);
		logic [2:0] fwd;
		logic [2:0] rev;
		fwd = rnd[2:0];
		rev = 3'd7 - rnd[2:0];
		if (dec) begin
			key_index = (rnd < 5'd8) ? fwd : rev;
		end else begin
			key_index = (rnd < 5'd24) ? fwd : rev;
		end
	endfunction

	// Nibble i goes through S-box i.
	function automatic logic [31:0] substitute(input logic [31:0] x, input sbox_set_t sb);
		logic [3:0]  v;
		logic [31:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			v = x[4*i +: 4];
			r[4*i +: 4] = sb[i][{v, 2'b00} +: 4];
		end
		substitute = r;
	endfunction

	// Round function: add key, substitute, rotate left by 11.
	function automatic logic [31:0] round_fn(input logic [31:0] n1, input logic [31:0] key,
			input sbox_set_t sb);
		logic [31:0] t;
		t = substitute(n1 + key, sb);
		round_fn = {t[20:0], t[31:21]};
	endfunction

endpackage

// ----- design/gost_block_cipher_ecb.sv -----
// Channel  | Handshake                | Payload
// ---------+--------------------------+------------------------------------------------
// input    | in_valid / in_stall      | kind, block_low, block_high, sbox_number, sbox_row
// output   | out_valid / out_stall    | out_low, out_high
// config   | cfg_we (no wait)         | cfg_index, cfg_data
//
// One round per pipeline stage, 32 stages; a block is accepted every cycle unless the
// output stalls with stages 0 to 31 all full; its result passes every stage register
// in order, held back only by output stall. A stalled output holds the last stage;
// earlier stages keep filling bubbles. An S-box load waits (in_stall high) until no
// block is in stages 0 to 30, then writes its row at the transfer.
// Reset clears the key words and all stage valid bits; S-box rows start unknown.
`include "gost_block_cipher_ecb_assert.svh"

module gost_block_cipher_ecb import gbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// Input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] block_low,
	input  logic [31:0] block_high,
	input  logic [2:0]  sbox_number,
	input  logic [63:0] sbox_row,
	// Output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_low,
	output logic [31:0] out_high
);

	key_set_t  key_q;
	sbox_set_t sbox_q;

	// Pipeline registers, entry k holds the state after round k.
	logic [ROUNDS-1:0] vld_s;
	logic [ROUNDS-1:0] dec_s;
	logic [31:0]       n1_s [ROUNDS];
	logic [31:0]       n2_s [ROUNDS];

	// Next values and stage ready flags.
	logic [ROUNDS-1:0] src_vld;
	logic [ROUNDS-1:0] src_dec;
	logic [ROUNDS-1:0] rdy;
	logic [31:0]       nxt_n1 [ROUNDS];
	logic [31:0]       nxt_n2 [ROUNDS];

	logic in_crypt;
	logic busy;
	logic in_xfer;

	// Decode the incoming item and decide when it may transfer.
	assign busy = |vld_s[ROUNDS-2:0];

	always_comb begin
		in_crypt = 1'b0;
		in_stall = 1'b0;
		unique case (kind)
			KIND_LOAD: begin
				in_stall = busy;
			end
			KIND_ENC, KIND_DEC: begin
				in_crypt = 1'b1;
				in_stall = !rdy[0];
			end
			KIND_NONE: begin
				in_stall = 1'b0;
			end
		endcase
	end

	assign in_xfer = in_valid && !in_stall;

	// Key words are written through the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	// S-box rows are written by load items.
	always_ff @(posedge clk) begin
		if (in_xfer && kind == KIND_LOAD) begin
			sbox_q[sbox_number] <= sbox_row;
		end
	end

	// Round logic for each stage.
	for (genvar k = 0; k < ROUNDS; k++) begin : g_round
		logic [31:0] a_n1;
		logic [31:0] a_n2;
		logic [31:0] key;
		logic [31:0] sum;

		// A stage takes new data when it is empty or its successor moves.
		assign rdy[k] = !out_stall || !(&vld_s[ROUNDS-1:k]);

		if (k == 0) begin : g_first
			assign src_vld[k] = in_valid && in_crypt && !in_stall;
			assign src_dec[k] = (kind == KIND_DEC);
			assign a_n1       = block_low;
			assign a_n2       = block_high;
		end else begin : g_next
			assign src_vld[k] = vld_s[k-1];
			assign src_dec[k] = dec_s[k-1];
			assign a_n1       = n1_s[k-1];
			assign a_n2       = n2_s[k-1];
		end

		assign key = key_q[key_index(5'(k), src_dec[k])];
		assign sum = a_n2 ^ round_fn(a_n1, key, sbox_q);

		// The last round does not swap the halves.
		if (k == ROUNDS - 1) begin : g_last
			assign nxt_n1[k] = a_n1;
			assign nxt_n2[k] = sum;
		end else begin : g_swap
			assign nxt_n1[k] = sum;
			assign nxt_n2[k] = a_n1;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < ROUNDS; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= src_vld[k];
				end
			end
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		for (int k = 0; k < ROUNDS; k++) begin
			if (rdy[k] && src_vld[k]) begin
				dec_s[k] <= src_dec[k];
				n1_s[k]  <= nxt_n1[k];
				n2_s[k]  <= nxt_n2[k];
			end
		end
	end

	// The last stage is the output register.
	assign out_valid = vld_s[ROUNDS-1];
	assign out_low   = n1_s[ROUNDS-1];
	assign out_high  = n2_s[ROUNDS-1];

	// A load never overlaps blocks that are still being worked on.
	`GBC_ASSERT_SAME(a_load_idle, in_xfer && kind == KIND_LOAD, !busy)
	// An empty output stage lets every stage move.
	`GBC_ASSERT_SAME(a_rdy_chain, !vld_s[ROUNDS-1], &rdy)
	// A block transfer lands in the first stage.
	`GBC_ASSERT_NEXT(a_enter, in_xfer && in_crypt, vld_s[0])
	// Data moves on between stages one and two when stage two is ready to take it.
	`GBC_ASSERT_NEXT(a_advance, vld_s[0] && rdy[1], vld_s[1])

endmodule
